// ----- rtl/tqbpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool manager package
// Shared widths, request and status codes, queue codes and payload structs.
// ----------------------------------------------------------------------------
package tqbpm_pkg;

	localparam int MAX_BUFFERS_DEFAULT = 16;

	// Field and register widths
	localparam int REQ_W      = 3;
	localparam int IDX_W      = 4;
	localparam int STATUS_W   = 3;
	localparam int ADDR_W     = 33;
	localparam int COUNT_W    = 5;
	localparam int SIZE_W     = 21;
	localparam int BASE_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INIT     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET_NEXT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_GET_FREE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PEEK     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FINISH   = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_INIT  = 3'd4;

	// Queue numbers; a buffer's tag is its queue number plus one
	localparam logic [1:0] Q_FREE   = 2'd0;
	localparam logic [1:0] Q_READY  = 2'd1;
	localparam logic [1:0] Q_FLIGHT = 2'd2;
	localparam logic [1:0] TAG_NONE = 2'd0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd3;

	// Configuration reset values
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 21'd4096;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [IDX_W-1:0] buffer_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    result_index;
		logic [ADDR_W-1:0]   result_address;
	} rsp_t;

endpackage

// ----- rtl/tqbpm_link_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link memories
// Next-link memory and a tag/prev-link memory, both with registered reads,
// plus per-entry valid bits that make never-written tags read as no queue.
// ----------------------------------------------------------------------------
module tqbpm_link_mem import tqbpm_pkg::*; #(
	parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT,
	localparam int IW = $clog2(MAX_BUFFERS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [IW-1:0] rd_next,
	output logic [IW-1:0] rd_prev,
	output logic [1:0]    rd_tag,
	input  logic          nx_we,
	input  logic [IW-1:0] nx_addr,
	input  logic [IW-1:0] nx_data,
	input  logic          pv_we,
	input  logic [IW-1:0] pv_addr,
	input  logic [1:0]    pv_tag,
	input  logic [IW-1:0] pv_data
);

	logic [IW-1:0]          next_mem [MAX_BUFFERS];
	logic [IW+1:0]          prev_mem [MAX_BUFFERS];
	logic [MAX_BUFFERS-1:0] valid_q;
	logic [IW-1:0]          rd_next_q;
	logic [IW+1:0]          rd_word_q;
	logic                   rd_valid_q;

	// Next-link memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_addr] <= nx_data;
		end
		if (rd_en) begin
			rd_next_q <= next_mem[rd_addr];
		end
	end

	// Tag and prev-link memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_addr] <= {pv_tag, pv_data};
		end
		if (rd_en) begin
			rd_word_q <= prev_mem[rd_addr];
		end
	end

	// Valid bits: drop all on clear, mark on tag write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (pv_we) begin
				valid_q[pv_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_next = rd_next_q;
	assign rd_prev = rd_word_q[IW-1:0];
	assign rd_tag  = rd_valid_q ? rd_word_q[IW+1:IW] : TAG_NONE;

`ifndef ASSERT_OFF
	a_clr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr && pv_we))
		else $error("tag write collides with valid clear");
`endif

endmodule

// ----- rtl/tqbpm_resp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response stage
// Forms the buffer address base + size * index and holds the result in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module tqbpm_resp import tqbpm_pkg::*; #(
	parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT,
	localparam int IW = $clog2(MAX_BUFFERS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	output logic                go_ready,
	input  logic [STATUS_W-1:0] go_status,
	input  logic                go_with_addr,
	input  logic [IW-1:0]       go_buf,
	input  logic [SIZE_W-1:0]   cfg_size,
	input  logic [BASE_W-1:0]   cfg_base,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp
);

	localparam int PW = SIZE_W + IW;

	logic [PW-1:0]     prod;
	logic [ADDR_W-1:0] addr;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// Address of the named buffer
	assign prod = PW'(cfg_size) * PW'(go_buf);
	assign addr = ADDR_W'(cfg_base) + ADDR_W'(prod);

	assign go_ready = !rsp_valid_q || rsp_ready;

	// Hold valid until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the result; index and address read zero unless a buffer is named
	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.status         <= go_status;
			rsp_q.result_index   <= go_with_addr ? IDX_W'(go_buf) : '0;
			rsp_q.result_address <= go_with_addr ? addr : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_go_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> go_ready)
		else $error("result handed over while output register is occupied");
`endif

endmodule

// ----- rtl/tqbpm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue sequencer
// Decodes requests, keeps queue heads, tails and lengths, and steps the
// unlink and append of a buffer through the link memories.
// ----------------------------------------------------------------------------
module tqbpm_seq import tqbpm_pkg::*; #(
	parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT,
	localparam int IW = $clog2(MAX_BUFFERS),
	localparam int LW = $clog2(MAX_BUFFERS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	input  logic                cfg_dir,
	input  logic [COUNT_W-1:0]  cfg_count,
	input  logic [SIZE_W-1:0]   cfg_size,
	output logic                mem_clr,
	output logic                mem_rd_en,
	output logic [IW-1:0]       mem_rd_addr,
	input  logic [IW-1:0]       mem_rd_next,
	input  logic [IW-1:0]       mem_rd_prev,
	input  logic [1:0]          mem_rd_tag,
	output logic                nx_we,
	output logic [IW-1:0]       nx_addr,
	output logic [IW-1:0]       nx_data,
	output logic                pv_we,
	output logic [IW-1:0]       pv_addr,
	output logic [1:0]          pv_tag,
	output logic [IW-1:0]       pv_data,
	output logic                go,
	input  logic                go_ready,
	output logic [STATUS_W-1:0] go_status,
	output logic                go_with_addr,
	output logic [IW-1:0]       go_buf
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_DROP,
		S_APPEND,
		S_LINK,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       head_q [3];
	logic [IW-1:0]       tail_q [3];
	logic [LW-1:0]       len_q [3];
	logic                pool_ready_q;
	logic [IW-1:0]       buf_q;
	logic [1:0]          dst_q;
	logic [STATUS_W-1:0] status_q;
	logic                with_addr_q;
	logic [IW-1:0]       fill_q;
	logic [IW-1:0]       last_q;
	logic [IW-1:0]       old_tail_q;

	logic [STATUS_W-1:0] dec_status;
	logic                dec_move;
	logic [IW-1:0]       dec_buf;
	logic [1:0]          dec_dst;
	logic [IW-1:0]       fill_last;
	logic                drop_tagged;
	logic [1:0]          drop_q;
	logic                req_xfer;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;

	// Last buffer built by init: count clamped to the pool size
	assign fill_last = (int'(cfg_count) > MAX_BUFFERS) ? IW'(MAX_BUFFERS - 1)
		: IW'(cfg_count - COUNT_W'(1));

	// Decode the request against the current queue state
	always_comb begin
		dec_status = STAT_OK;
		dec_move   = 1'b0;
		dec_buf    = IW'(req.buffer_index);
		dec_dst    = Q_READY;
		unique case (req.req_type)
			REQ_INIT: begin
				dec_dst = cfg_dir ? Q_FREE : Q_READY;
				if (cfg_count == '0 || cfg_size == '0) begin
					dec_status = STAT_BAD_INDEX;
				end
			end
			REQ_GET_NEXT: begin
				dec_dst = Q_FLIGHT;
				dec_buf = head_q[Q_READY];
				if (!pool_ready_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (len_q[Q_READY] == '0) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_move = 1'b1;
				end
			end
			REQ_GET_FREE: begin
				dec_dst = Q_FLIGHT;
				dec_buf = head_q[Q_FREE];
				if (!pool_ready_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (!cfg_dir) begin
					dec_status = STAT_REFUSED;
				end else if (len_q[Q_FREE] == '0) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_move = 1'b1;
				end
			end
			REQ_PEEK: begin
				dec_buf = head_q[Q_FLIGHT];
				if (!pool_ready_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (len_q[Q_FLIGHT] == '0) begin
					dec_status = STAT_EMPTY;
				end
			end
			REQ_FINISH: begin
				if (!pool_ready_q) begin
					dec_status = STAT_NOT_INIT;
				end else if ({1'b0, req.buffer_index} >= cfg_count
					|| int'(req.buffer_index) >= MAX_BUFFERS) begin
					dec_status = STAT_BAD_INDEX;
				end else begin
					dec_move = 1'b1;
				end
			end
			default: begin
				dec_status = STAT_REFUSED;
			end
		endcase
	end

	// Unlink view of the buffer just read
	assign drop_tagged = (mem_rd_tag != TAG_NONE);
	assign drop_q      = mem_rd_tag - 2'd1;

	// Memory read on accept, clear on init
	assign mem_rd_en   = req_xfer;
	assign mem_rd_addr = dec_buf;
	assign mem_clr     = req_xfer && (req.req_type == REQ_INIT);

	// Link memory writes per step
	always_comb begin
		nx_we   = 1'b0;
		nx_addr = buf_q;
		nx_data = buf_q;
		pv_we   = 1'b0;
		pv_addr = buf_q;
		pv_tag  = dst_q + 2'd1;
		pv_data = buf_q;
		unique case (state_q)
			S_FILL: begin
				nx_we   = 1'b1;
				nx_addr = fill_q;
				nx_data = (fill_q == last_q) ? fill_q : fill_q + IW'(1);
				pv_we   = 1'b1;
				pv_addr = fill_q;
				pv_data = (fill_q == '0) ? '0 : fill_q - IW'(1);
			end
			S_DROP: begin
				nx_we   = drop_tagged && (head_q[drop_q] != buf_q);
				nx_addr = mem_rd_prev;
				nx_data = mem_rd_next;
				pv_we   = drop_tagged && (tail_q[drop_q] != buf_q);
				pv_addr = mem_rd_next;
				pv_tag  = mem_rd_tag;
				pv_data = mem_rd_prev;
			end
			S_APPEND: begin
				nx_we   = 1'b1;
				pv_we   = 1'b1;
				pv_data = (len_q[dst_q] == '0) ? buf_q : tail_q[dst_q];
			end
			S_LINK: begin
				nx_we   = 1'b1;
				nx_addr = old_tail_q;
			end
			default: begin
			end
		endcase
	end

	// State, queue registers and response fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_ready_q <= 1'b0;
			buf_q        <= '0;
			dst_q        <= Q_FREE;
			status_q     <= STAT_OK;
			with_addr_q  <= 1'b0;
			fill_q       <= '0;
			last_q       <= '0;
			old_tail_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q    <= dec_status;
						buf_q       <= dec_buf;
						dst_q       <= dec_dst;
						with_addr_q <= (dec_status == STAT_OK) && (req.req_type != REQ_INIT);
						if (req.req_type == REQ_INIT) begin
							pool_ready_q <= 1'b0;
							fill_q       <= '0;
							last_q       <= fill_last;
							for (int i = 0; i < 3; i++) begin
								head_q[i] <= '0;
								tail_q[i] <= '0;
								len_q[i]  <= '0;
							end
							state_q <= (dec_status == STAT_OK) ? S_FILL : S_RESP;
						end else begin
							state_q <= dec_move ? S_DROP : S_RESP;
						end
					end
				end
				S_FILL: begin
					if (fill_q == last_q) begin
						head_q[dst_q] <= '0;
						tail_q[dst_q] <= last_q;
						len_q[dst_q]  <= LW'(last_q) + LW'(1);
						pool_ready_q  <= 1'b1;
						state_q       <= S_RESP;
					end else begin
						fill_q <= fill_q + IW'(1);
					end
				end
				S_DROP: begin
					if (drop_tagged) begin
						if (head_q[drop_q] == buf_q) begin
							head_q[drop_q] <= mem_rd_next;
						end
						if (tail_q[drop_q] == buf_q) begin
							tail_q[drop_q] <= mem_rd_prev;
						end
						if (len_q[drop_q] != '0) begin
							len_q[drop_q] <= len_q[drop_q] - LW'(1);
						end
					end
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					if (len_q[dst_q] == '0) begin
						head_q[dst_q] <= buf_q;
					end
					old_tail_q    <= tail_q[dst_q];
					tail_q[dst_q] <= buf_q;
					len_q[dst_q]  <= len_q[dst_q] + LW'(1);
					state_q       <= (len_q[dst_q] == '0) ? S_RESP : S_LINK;
				end
				S_LINK: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (go_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hand the result over only once the output register can take it
	assign go           = (state_q == S_RESP) && go_ready;
	assign go_status    = status_q;
	assign go_with_addr = with_addr_q;
	assign go_buf       = buf_q;

`ifndef ASSERT_OFF
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(len_q[0]) + int'(len_q[1]) + int'(len_q[2])) <= MAX_BUFFERS)
		else $error("queues hold more buffers than the pool");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pool_ready_q) |-> $past(req_xfer && req.req_type == REQ_INIT))
		else $error("pool lost its initialized state without an init");

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && go_ready) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after handing over");
`endif

endmodule

// ----- rtl/three_queue_buffer_pool_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-queue buffer pool manager
// Keeps every buffer of a pool in a free, ready or in-flight queue held as
// doubly linked lists in link memories, and answers one result per request.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload      direction
//  req       req_valid/req_ready   req_t        in
//  rsp       rsp_valid/rsp_ready   rsp_t        out
//  cfg       cfg_valid/cfg_ready   index, data  in, always ready
//
//  Steps after transfer: peek and refused or failed requests go straight to
//  the response step; get-next, get-free and finish unlink, append and, when
//  the target queue is not empty, add a tail link; init links the clamped
//  buffer count first. The next request is taken the cycle after the result
//  is loaded. Reset leaves the pool not initialized; a stalled output holds
//  the sequencer in its response step and no new request is taken.
// ----------------------------------------------------------------------------
module three_queue_buffer_pool_manager import tqbpm_pkg::*; #(
	parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_BUFFERS);

	logic                dir_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BASE_W-1:0]   base_q;

	logic                mem_clr;
	logic                mem_rd_en;
	logic [IW-1:0]       mem_rd_addr;
	logic [IW-1:0]       mem_rd_next;
	logic [IW-1:0]       mem_rd_prev;
	logic [1:0]          mem_rd_tag;
	logic                nx_we;
	logic [IW-1:0]       nx_addr;
	logic [IW-1:0]       nx_data;
	logic                pv_we;
	logic [IW-1:0]       pv_addr;
	logic [1:0]          pv_tag;
	logic [IW-1:0]       pv_data;
	logic                go;
	logic                go_ready;
	logic [STATUS_W-1:0] go_status;
	logic                go_with_addr;
	logic [IW-1:0]       go_buf;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 1'b0;
			count_q <= COUNT_RESET;
			size_q  <= SIZE_RESET;
			base_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DIRECTION: dir_q   <= cfg_data[0];
				CFG_COUNT:     count_q <= cfg_data[COUNT_W-1:0];
				CFG_SIZE:      size_q  <= cfg_data[SIZE_W-1:0];
				CFG_BASE:      base_q  <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tqbpm_seq #(
		.MAX_BUFFERS(MAX_BUFFERS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.cfg_dir      (dir_q),
		.cfg_count    (count_q),
		.cfg_size     (size_q),
		.mem_clr      (mem_clr),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_next  (mem_rd_next),
		.mem_rd_prev  (mem_rd_prev),
		.mem_rd_tag   (mem_rd_tag),
		.nx_we        (nx_we),
		.nx_addr      (nx_addr),
		.nx_data      (nx_data),
		.pv_we        (pv_we),
		.pv_addr      (pv_addr),
		.pv_tag       (pv_tag),
		.pv_data      (pv_data),
		.go           (go),
		.go_ready     (go_ready),
		.go_status    (go_status),
		.go_with_addr (go_with_addr),
		.go_buf       (go_buf)
	);

	tqbpm_link_mem #(
		.MAX_BUFFERS(MAX_BUFFERS)
	) u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (mem_clr),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_next (mem_rd_next),
		.rd_prev (mem_rd_prev),
		.rd_tag  (mem_rd_tag),
		.nx_we   (nx_we),
		.nx_addr (nx_addr),
		.nx_data (nx_data),
		.pv_we   (pv_we),
		.pv_addr (pv_addr),
		.pv_tag  (pv_tag),
		.pv_data (pv_data)
	);

	tqbpm_resp #(
		.MAX_BUFFERS(MAX_BUFFERS)
	) u_resp (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.go_ready     (go_ready),
		.go_status    (go_status),
		.go_with_addr (go_with_addr),
		.go_buf       (go_buf),
		.cfg_size     (size_q),
		.cfg_base     (base_q),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp)
	);

endmodule

// ----- tb/sv/tqbpm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool manager checker
// Watches the request, response and configuration channels, keeps its own
// copy of the free, ready and in-flight queues, works out one answer per
// accepted request and compares every response with the oldest answer due.
// ----------------------------------------------------------------------------
module tqbpm_checker import tqbpm_pkg::*; #(
	parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_t                  rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    answers_due
);

	// Mirrored configuration
	logic               mode_capture;
	logic [COUNT_W-1:0] pool_count;
	logic [SIZE_W-1:0]  stride;
	logic [BASE_W-1:0]  base_addr;

	// Mirrored queue state
	logic [1:0]       tag_of   [MAX_BUFFERS];
	logic [IDX_W-1:0] fwd_link [MAX_BUFFERS];
	logic [IDX_W-1:0] back_link[MAX_BUFFERS];
	logic [IDX_W-1:0] q_head   [3];
	logic [IDX_W-1:0] q_tail   [3];
	logic [COUNT_W:0] q_len    [3];
	logic             pool_live;

	rsp_t pending_answers[$];
	rsp_t answer_next;
	rsp_t answer_want;
	int   fail_count;

	task automatic flag_mismatch(input string field, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		$display("%0t: response %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
		fail_count++;
	endtask

	task automatic empty_queues();
		for (int i = 0; i < MAX_BUFFERS; i++) begin
			tag_of[i] = TAG_NONE;
		end
		for (int q = 0; q < 3; q++) begin
			q_head[q] = '0;
			q_tail[q] = '0;
			q_len[q]  = '0;
		end
	endtask

	// Take a buffer out of whatever queue holds it
	task automatic unlink_buffer(input logic [IDX_W-1:0] b);
		logic [1:0]       q;
		logic [IDX_W-1:0] p;
		logic [IDX_W-1:0] n;
		if (tag_of[b] == TAG_NONE) begin
			return;
		end
		q = tag_of[b] - 2'd1;
		p = back_link[b];
		n = fwd_link[b];
		if (q_head[q] == b) begin
			q_head[q] = n;
		end else begin
			fwd_link[p] = n;
		end
		if (q_tail[q] == b) begin
			q_tail[q] = p;
		end else begin
			back_link[n] = p;
		end
		if (q_len[q] != 0) begin
			q_len[q]--;
		end
		tag_of[b] = TAG_NONE;
	endtask

	// Append a buffer at the tail of a queue
	task automatic link_at_tail(input logic [1:0] q, input logic [IDX_W-1:0] b);
		if (q_len[q] == 0) begin
			q_head[q]    = b;
			back_link[b] = b;
		end else begin
			fwd_link[q_tail[q]] = b;
			back_link[b]        = q_tail[q];
		end
		fwd_link[b] = b;
		q_tail[q]   = b;
		q_len[q]++;
		tag_of[b] = q + 2'd1;
	endtask

	// Move the head of a queue to the in-flight tail
	task automatic take_head(input logic [1:0] q, output logic [STATUS_W-1:0] st,
			output logic [IDX_W-1:0] b);
		b = '0;
		if (q_len[q] == 0) begin
			st = STAT_EMPTY;
		end else begin
			b = q_head[q];
			unlink_buffer(b);
			link_at_tail(Q_FLIGHT, b);
			st = STAT_OK;
		end
	endtask

	// Work out the answer to one request and update the mirrored queues
	task automatic compute_answer(input req_t r, output rsp_t a);
		logic [STATUS_W-1:0] st;
		logic [IDX_W-1:0]    b;
		int                  n;
		st = STAT_OK;
		b  = '0;
		if (r.req_type > REQ_FINISH) begin
			st = STAT_REFUSED;
		end else if (r.req_type == REQ_INIT) begin
			empty_queues();
			pool_live = 1'b0;
			if (pool_count == 0 || stride == 0) begin
				st = STAT_BAD_INDEX;
			end else begin
				n = (pool_count > MAX_BUFFERS) ? MAX_BUFFERS : int'(pool_count);
				for (int i = 0; i < n; i++) begin
					link_at_tail(mode_capture ? Q_FREE : Q_READY, IDX_W'(i));
				end
				pool_live = 1'b1;
			end
		end else if (!pool_live) begin
			st = STAT_NOT_INIT;
		end else begin
			case (r.req_type)
				REQ_GET_NEXT: begin
					take_head(Q_READY, st, b);
				end
				REQ_GET_FREE: begin
					if (!mode_capture) begin
						st = STAT_REFUSED;
					end else begin
						take_head(Q_FREE, st, b);
					end
				end
				REQ_PEEK: begin
					if (q_len[Q_FLIGHT] == 0) begin
						st = STAT_EMPTY;
					end else begin
						b = q_head[Q_FLIGHT];
					end
				end
				default: begin
					if (r.buffer_index >= pool_count || r.buffer_index >= MAX_BUFFERS) begin
						st = STAT_BAD_INDEX;
					end else begin
						b = r.buffer_index;
						unlink_buffer(b);
						link_at_tail(Q_READY, b);
					end
				end
			endcase
		end
		a.status = st;
		if (st == STAT_OK && r.req_type != REQ_INIT) begin
			a.result_index   = b;
			a.result_address = ADDR_W'(base_addr) + ADDR_W'(stride) * ADDR_W'(b);
		end else begin
			a.result_index   = '0;
			a.result_address = '0;
		end
	endtask

	// Track configuration, compare responses, queue new answers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_capture = 1'b0;
			pool_count   = COUNT_RESET;
			stride       = SIZE_RESET;
			base_addr    = '0;
			pool_live    = 1'b0;
			empty_queues();
			pending_answers.delete();
			fail_count  = 0;
			errors      <= 0;
			answers_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DIRECTION: mode_capture = cfg_data[0];
					CFG_COUNT:     pool_count   = cfg_data[COUNT_W-1:0];
					CFG_SIZE:      stride       = cfg_data[SIZE_W-1:0];
					default:       base_addr    = cfg_data[BASE_W-1:0];
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: response transfer with no answer due", $time);
					fail_count++;
				end else begin
					answer_want = pending_answers.pop_front();
					if (rsp.status !== answer_want.status) begin
						flag_mismatch("status", ADDR_W'(rsp.status), ADDR_W'(answer_want.status));
					end
					if (rsp.result_index !== answer_want.result_index) begin
						flag_mismatch("index", ADDR_W'(rsp.result_index),
							ADDR_W'(answer_want.result_index));
					end
					if (rsp.result_address !== answer_want.result_address) begin
						flag_mismatch("address", rsp.result_address, answer_want.result_address);
					end
				end
			end
			if (req_valid && req_ready) begin
				compute_answer(req, answer_next);
				pending_answers.push_back(answer_next);
			end
			errors      <= fail_count;
			answers_due <= pending_answers.size();
		end
	end

endmodule

// ----- tb/sv/tb_three_queue_buffer_pool_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool manager testbench
// Drives directed and random requests and configuration settings into the
// pool manager with random gaps and output stalls; the checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_three_queue_buffer_pool_manager;
	import tqbpm_pkg::*;

	localparam int RUN_LIMIT   = 500000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 100;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int                    errors;
	int                    answers_due;
	int                    cycle_count;
	int                    stall_left  = 0;
	bit                    steady      = 1'b0;
	logic [COUNT_W-1:0]    live_count;
	logic [CFG_DATA_W-1:0] pick_dir;
	logic [CFG_DATA_W-1:0] pick_count;
	logic [CFG_DATA_W-1:0] pick_size;
	logic [CFG_DATA_W-1:0] pick_base;
	int                    roll;
	logic [IDX_W-1:0]      pick_idx;

	three_queue_buffer_pool_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tqbpm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.answers_due (answers_due)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Stall the response side at random
	always @(posedge clk) begin
		if (steady) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(99) < 25) begin
			stall_left = idle_len();
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Hold off until every answer due has come back
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (answers_due != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
	endtask

	// Write all four registers once the block is idle
	task automatic set_config(input logic [CFG_DATA_W-1:0] dir,
			input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] size,
			input logic [CFG_DATA_W-1:0] base);
		wait_idle();
		put_reg(CFG_DIRECTION, dir);
		put_reg(CFG_COUNT, count);
		put_reg(CFG_SIZE, size);
		put_reg(CFG_BASE, base);
		cfg_valid  <= 1'b0;
		live_count = count[COUNT_W-1:0];
	endtask

	// Issue one request after a random gap and hold it until the transfer
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid        <= 1'b1;
		req.req_type     <= kind;
		req.buffer_index <= idx;
		do begin
			@(posedge clk);
		end while (!req_ready);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before init: known requests read not initialized, unknown codes are refused
		send_request(REQ_GET_NEXT, '0);
		send_request(REQ_PEEK, '0);
		send_request(REQ_FINISH, '0);
		send_request(3'd7, 4'hF);
		// Playback pool with the reset settings
		send_request(REQ_INIT, '0);
		send_request(REQ_GET_FREE, '0);
		send_request(REQ_PEEK, '0);
		send_request(REQ_GET_NEXT, '0);
		send_request(REQ_GET_NEXT, '0);
		send_request(REQ_PEEK, '0);
		send_request(REQ_FINISH, 4'd0);
		send_request(REQ_FINISH, 4'd15);
		send_request(REQ_FINISH, 4'd5);
		send_request(3'd5, 4'd3);
		send_request(3'd6, 4'd9);

		// Capture pool, count above the pool size, widest stride and base
		set_config(32'd1, 32'd31, 32'h1F_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_INIT, '0);
		send_request(REQ_GET_FREE, '0);
		send_request(REQ_GET_NEXT, '0);
		send_request(REQ_FINISH, 4'd15);
		send_request(REQ_GET_NEXT, '0);
		send_request(REQ_INIT, '0);

		// Zero count, then zero size: init fails and the pool goes dead
		set_config(32'd1, 32'd0, 32'd1048576, 32'h8000_0000);
		send_request(REQ_INIT, '0);
		send_request(REQ_GET_NEXT, '0);
		set_config(32'd0, 32'd4, 32'd0, 32'd0);
		send_request(REQ_INIT, '0);

		// Small pool, then raise the count without a new init
		set_config(32'd1, 32'd4, 32'd1, 32'd0);
		send_request(REQ_INIT, '0);
		set_config(32'd1, 32'd8, 32'd1, 32'd0);
		send_request(REQ_FINISH, 4'd6);
		send_request(REQ_FINISH, 4'd8);

		// Random phases, each under its own settings
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			pick_dir = $urandom_range(1);
			case ($urandom_range(15))
				0:       pick_count = 32'd1;
				1:       pick_count = 32'd16;
				2:       pick_count = 32'd31;
				3:       pick_count = 32'd0;
				4:       pick_count = $urandom_range(17, 31);
				default: pick_count = $urandom_range(1, 16);
			endcase
			case ($urandom_range(11))
				0:       pick_size = 32'd1;
				1:       pick_size = 32'h1F_FFFF;
				2:       pick_size = 32'd0;
				3:       pick_size = 32'd4096;
				default: pick_size = $urandom_range(1, 32'h1F_FFFF);
			endcase
			case ($urandom_range(3))
				0:       pick_base = 32'd0;
				1:       pick_base = 32'hFFFF_FFFF;
				default: pick_base = $urandom;
			endcase
			set_config(pick_dir, pick_count, pick_size, pick_base);
			steady = (phase % 4 == 3);

			// Usually rebuild; otherwise keep the old queues under new settings
			if ($urandom_range(3) != 0) begin
				send_request(REQ_INIT, '0);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (live_count == 0 || $urandom_range(9) == 0) begin
					pick_idx = $urandom_range(15);
				end else if (live_count > 16) begin
					pick_idx = $urandom_range(15);
				end else begin
					pick_idx = $urandom_range(int'(live_count) - 1);
				end
				roll = $urandom_range(99);
				if (roll < 3) begin
					send_request(REQ_INIT, pick_idx);
				end else if (roll < 33) begin
					send_request(REQ_GET_NEXT, pick_idx);
				end else if (roll < 50) begin
					send_request(REQ_GET_FREE, pick_idx);
				end else if (roll < 62) begin
					send_request(REQ_PEEK, pick_idx);
				end else if (roll < 94) begin
					send_request(REQ_FINISH, pick_idx);
				end else begin
					send_request(REQ_W'($urandom_range(5, 7)), pick_idx);
				end
			end
			steady = 1'b0;
		end

		// Drain and give the verdict
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
